// File: hdl/cpfp_pkg.sv
// Package for the common prime factor product unit.
// Holds default parameter values, the result width and the state types.
// No dependencies; the lane, merge, top-level and checker files refer to it by scoped names.
package cpfp_pkg;

    // Default list depth and operand width.
    localparam int MAX_FACTORS_DEF = 32;
    localparam int VALUE_BITS_DEF  = 31;

    // Width of the common_product result field.
    localparam int OUT_BITS = 31;

    // Sequencing of the whole unit.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FACTOR,
        PH_MERGE
    } phase_t;

    // Trial division sequencer of one factoring lane.
    typedef enum logic [1:0] {
        L_IDLE,
        L_START,
        L_DIV
    } lane_state_t;

    // Merge walk over the two factor lists.
    typedef enum logic [2:0] {
        M_IDLE,
        M_FETCH,
        M_CMP,
        M_MUL,
        M_OUT
    } merge_state_t;

endpackage

// File: hdl/cpfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/cpfp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but its WIDTH parameter.
module cpfp_div #(
    parameter int WIDTH = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNTW = $clog2(WIDTH);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        run_next  = run_reg;
        done_next = run_reg && (cnt_reg == '0);
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNTW'(WIDTH - 1);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/cpfp_lane.sv
// One factoring lane: trial division of a value, writing each prime factor
// into its list memory. Depends on cpfp_pkg and cpfp_div.
module cpfp_lane #(
    parameter int VALUE_BITS  = cpfp_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = cpfp_pkg::MAX_FACTORS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [VALUE_BITS-1:0]            value,
    output logic                             busy,
    output logic                             wr_en,
    output logic [$clog2(MAX_FACTORS)-1:0]   wr_addr,
    output logic [VALUE_BITS-1:0]            wr_data,
    output logic [$clog2(MAX_FACTORS+1)-1:0] count
);

    localparam int AW = $clog2(MAX_FACTORS);
    localparam int CW = $clog2(MAX_FACTORS + 1);

    cpfp_pkg::lane_state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [CW-1:0]         n_reg, n_next;

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] quotient;
    logic [VALUE_BITS-1:0] remainder;
    logic                  room;
    logic                  last_trial;

    cpfp_div #(
        .WIDTH(VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quotient),
        .remainder(remainder)
    );

    assign room       = (n_reg < CW'(MAX_FACTORS));
    // The divisor has passed the square root of what is left.
    assign last_trial = (d_reg > quotient);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpfp_pkg::L_IDLE:
            begin
                if (start)
                begin
                    state_next = cpfp_pkg::L_START;
                end
            end
            cpfp_pkg::L_START:
            begin
                state_next = (v_reg < VALUE_BITS'(2)) ? cpfp_pkg::L_IDLE : cpfp_pkg::L_DIV;
            end
            cpfp_pkg::L_DIV:
            begin
                if (div_done)
                begin
                    state_next = last_trial ? cpfp_pkg::L_IDLE : cpfp_pkg::L_START;
                end
            end
            default:
            begin
                state_next = cpfp_pkg::L_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == cpfp_pkg::L_START) && (v_reg >= VALUE_BITS'(2));
        wr_en     = 1'b0;
        wr_data   = d_reg;
        if ((state_reg == cpfp_pkg::L_DIV) && div_done && room)
        begin
            if (last_trial)
            begin
                wr_en   = (v_reg > VALUE_BITS'(1));
                wr_data = v_reg;
            end
            else if (remainder == '0)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_comb
    begin
        v_next = v_reg;
        d_next = d_reg;
        n_next = wr_en ? n_reg + 1'b1 : n_reg;
        if ((state_reg == cpfp_pkg::L_IDLE) && start)
        begin
            v_next = value;
            d_next = VALUE_BITS'(2);
            n_next = '0;
        end
        else if ((state_reg == cpfp_pkg::L_DIV) && div_done && !last_trial)
        begin
            if (remainder == '0)
            begin
                v_next = quotient;
            end
            else
            begin
                d_next = d_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpfp_pkg::L_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        d_reg <= d_next;
    end

    assign busy    = (state_reg != cpfp_pkg::L_IDLE);
    assign wr_addr = n_reg[AW-1:0];
    assign count   = n_reg;

endmodule

// File: hdl/cpfp_merge.sv
// Merge stage: walks both ascending factor lists, multiplies the matched
// factors with a shift-add unit and holds the result register.
// Depends on cpfp_pkg.
module cpfp_merge #(
    parameter int VALUE_BITS  = cpfp_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = cpfp_pkg::MAX_FACTORS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [$clog2(MAX_FACTORS+1)-1:0] count_a,
    input  logic [$clog2(MAX_FACTORS+1)-1:0] count_b,
    output logic [$clog2(MAX_FACTORS)-1:0]   raddr_a,
    output logic [$clog2(MAX_FACTORS)-1:0]   raddr_b,
    input  logic [VALUE_BITS-1:0]            rdata_a,
    input  logic [VALUE_BITS-1:0]            rdata_b,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cpfp_pkg::OUT_BITS-1:0]    common_product,
    output logic                             has_common
);

    localparam int AW  = $clog2(MAX_FACTORS);
    localparam int CW  = $clog2(MAX_FACTORS + 1);
    localparam int MCW = $clog2(VALUE_BITS);

    cpfp_pkg::merge_state_t state_reg, state_next;
    logic [CW-1:0]               i_reg, i_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [VALUE_BITS-1:0]       prod_reg, prod_next;
    logic [VALUE_BITS-1:0]       acc_reg, acc_next;
    logic [VALUE_BITS-1:0]       mcand_reg, mcand_next;
    logic [VALUE_BITS-1:0]       mplier_reg, mplier_next;
    logic [MCW-1:0]              mcnt_reg, mcnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cpfp_pkg::OUT_BITS-1:0] out_prod_reg, out_prod_next;
    logic                        out_has_reg, out_has_next;

    logic                  slot_free;
    logic                  in_range;
    logic [VALUE_BITS-1:0] acc_sum;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_range  = (i_reg < count_a) && (j_reg < count_b);
    assign acc_sum   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpfp_pkg::M_IDLE:
            begin
                if (start)
                begin
                    state_next = cpfp_pkg::M_FETCH;
                end
            end
            cpfp_pkg::M_FETCH:
            begin
                state_next = in_range ? cpfp_pkg::M_CMP : cpfp_pkg::M_OUT;
            end
            cpfp_pkg::M_CMP:
            begin
                state_next = (rdata_a == rdata_b) ? cpfp_pkg::M_MUL : cpfp_pkg::M_FETCH;
            end
            cpfp_pkg::M_MUL:
            begin
                if (mcnt_reg == '0)
                begin
                    state_next = cpfp_pkg::M_FETCH;
                end
            end
            cpfp_pkg::M_OUT:
            begin
                if (slot_free)
                begin
                    state_next = cpfp_pkg::M_IDLE;
                end
            end
            default:
            begin
                state_next = cpfp_pkg::M_IDLE;
            end
        endcase
    end

    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mcnt_next      = mcnt_reg;
        out_prod_next  = out_prod_reg;
        out_has_next   = out_has_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            cpfp_pkg::M_IDLE:
            begin
                if (start)
                begin
                    i_next    = '0;
                    j_next    = '0;
                    prod_next = VALUE_BITS'(1);
                end
            end
            cpfp_pkg::M_FETCH:
            begin
            end
            cpfp_pkg::M_CMP:
            begin
                if (rdata_a == rdata_b)
                begin
                    i_next      = i_reg + 1'b1;
                    j_next      = j_reg + 1'b1;
                    acc_next    = '0;
                    mcand_next  = prod_reg;
                    mplier_next = rdata_a;
                    mcnt_next   = MCW'(VALUE_BITS - 1);
                end
                else if (rdata_a < rdata_b)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            cpfp_pkg::M_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[VALUE_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[VALUE_BITS-1:1]};
                mcnt_next   = mcnt_reg - 1'b1;
                if (mcnt_reg == '0)
                begin
                    prod_next = acc_sum;
                end
            end
            cpfp_pkg::M_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_prod_next  = cpfp_pkg::OUT_BITS'(prod_reg);
                    out_has_next   = (prod_reg > VALUE_BITS'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpfp_pkg::M_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        mcnt_reg     <= mcnt_next;
        out_prod_reg <= out_prod_next;
        out_has_reg  <= out_has_next;
    end

    assign raddr_a        = i_reg[AW-1:0];
    assign raddr_b        = j_reg[AW-1:0];
    assign busy           = (state_reg != cpfp_pkg::M_IDLE);
    assign out_valid      = out_valid_reg;
    assign common_product = out_prod_reg;
    assign has_common     = out_has_reg;

endmodule

// File: hdl/common_prime_factor_product_unit.sv
// Top level of the common prime factor product unit.
// Depends on cpfp_pkg, cpfp_lane, cpfp_ram and cpfp_merge.
//
// Usage:
// The input channel (in_valid, in_stall, first_value, second_value) takes one
// pair of values per transaction. The output channel (out_valid, out_stall,
// common_product, has_common) returns one transaction per accepted pair: the
// product of the prime factors shared by both values, which is their gcd when
// both are at least 2, and 1 with has_common low when there is no shared
// factor or either value is 0 or 1.
// Two factoring lanes run in parallel, one per value, so the slower value sets
// the time. Each lane performs trial division with an iterative divider that
// yields one quotient bit per cycle. A value takes about p trials plus one per
// prime factor, where p is the larger of its second-largest prime factor and
// the square root of its largest one. A prime near 2^31 needs about 46,000
// trials. The merge stage then walks both lists and multiplies each shared
// factor into the product in a shift-add multiplier. One pair is in work at a
// time; in_stall stays high from acceptance until the result has moved into
// the output register, so the next pair can be taken while a finished result
// still waits on a stalled receiver. The output register holds a valid result
// while out_stall is high. Reset clears the state machines, control flags and
// the lane and divider counters; other registers and the factor list memories are not.
module common_prime_factor_product_unit #(
    parameter int MAX_FACTORS = cpfp_pkg::MAX_FACTORS_DEF,
    parameter int VALUE_BITS  = cpfp_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [VALUE_BITS-1:0]         first_value,
    input  logic [VALUE_BITS-1:0]         second_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cpfp_pkg::OUT_BITS-1:0] common_product,
    output logic                          has_common
);

    localparam int AW = $clog2(MAX_FACTORS);
    localparam int CW = $clog2(MAX_FACTORS + 1);

    cpfp_pkg::phase_t phase_reg, phase_next;

    logic                  accept;
    logic                  merge_start;
    logic                  merge_busy;

    logic                  busy_a, busy_b;
    logic                  wr_en_a, wr_en_b;
    logic [AW-1:0]         wr_addr_a, wr_addr_b;
    logic [VALUE_BITS-1:0] wr_data_a, wr_data_b;
    logic [CW-1:0]         count_a, count_b;
    logic [AW-1:0]         raddr_a, raddr_b;
    logic [VALUE_BITS-1:0] rdata_a, rdata_b;

    // Sequencing: factor both values, then merge the two lists.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            cpfp_pkg::PH_IDLE:
            begin
                if (accept)
                begin
                    phase_next = cpfp_pkg::PH_FACTOR;
                end
            end
            cpfp_pkg::PH_FACTOR:
            begin
                if (merge_start)
                begin
                    phase_next = cpfp_pkg::PH_MERGE;
                end
            end
            cpfp_pkg::PH_MERGE:
            begin
                if (!merge_busy)
                begin
                    phase_next = cpfp_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = cpfp_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = (phase_reg != cpfp_pkg::PH_IDLE);
        merge_start = (phase_reg == cpfp_pkg::PH_FACTOR) && !busy_a && !busy_b;
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cpfp_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Lane for the first value and its factor list.
    cpfp_lane #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FACTORS(MAX_FACTORS)
    ) u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (first_value),
        .busy   (busy_a),
        .wr_en  (wr_en_a),
        .wr_addr(wr_addr_a),
        .wr_data(wr_data_a),
        .count  (count_a)
    );

    cpfp_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_FACTORS)
    ) u_list_a (
        .clk  (clk),
        .we   (wr_en_a),
        .waddr(wr_addr_a),
        .wdata(wr_data_a),
        .raddr(raddr_a),
        .rdata(rdata_a)
    );

    // Lane for the second value and its factor list.
    cpfp_lane #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FACTORS(MAX_FACTORS)
    ) u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (second_value),
        .busy   (busy_b),
        .wr_en  (wr_en_b),
        .wr_addr(wr_addr_b),
        .wr_data(wr_data_b),
        .count  (count_b)
    );

    cpfp_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_FACTORS)
    ) u_list_b (
        .clk  (clk),
        .we   (wr_en_b),
        .waddr(wr_addr_b),
        .wdata(wr_data_b),
        .raddr(raddr_b),
        .rdata(rdata_b)
    );

    // Merge stage with the output register.
    cpfp_merge #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FACTORS(MAX_FACTORS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (merge_start),
        .count_a       (count_a),
        .count_b       (count_b),
        .raddr_a       (raddr_a),
        .raddr_b       (raddr_b),
        .rdata_a       (rdata_a),
        .rdata_b       (rdata_b),
        .busy          (merge_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .common_product(common_product),
        .has_common    (has_common)
    );

endmodule

// File: hdl/cpfp_checker.sv
// Port-level checker for the common prime factor product unit, with the bind
// that attaches it. Depends on cpfp_pkg and the top level's port names.
module cpfp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cpfp_pkg::OUT_BITS-1:0] common_product,
    input logic                          has_common
);

    // The flag agrees with the product it comes with.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_common == (common_product > cpfp_pkg::OUT_BITS'(1))))
    else $error("has_common disagrees with common_product");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(common_product) && $stable(has_common)))
    else $error("stalled result changed");

    // Once a pair is taken the unit is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction");

    // A new result appears only while its pair is still being retired.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
    else $error("result appeared with no pair in work");

endmodule

bind common_prime_factor_product_unit cpfp_checker u_cpfp_checker (.*);
